>>> hdl/button_report_event_queue_assert.svh
// Assertion macros shared by the event queue checkers.
// No dependencies; include by bare file name.
`ifndef BUTTON_REPORT_EVENT_QUEUE_ASSERT_SVH
`define BUTTON_REPORT_EVENT_QUEUE_ASSERT_SVH

// Check on every clock edge outside reset.
`define EVQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset cycles included.
`define EVQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/evq_pkg.sv
// Types, codes and the button bit table of the button event queue.
// No dependencies.
package evq_pkg;

  localparam int MASK_W           = 24;
  localparam int CODE_W           = 4;
  localparam int MIN_REPORT_BYTES = 3;

  localparam logic [1:0] KIND_REPORT     = 2'd0;
  localparam logic [1:0] KIND_POP        = 2'd1;
  localparam logic [1:0] KIND_LINK_RESET = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [MASK_W-1:0] report_mask;
    logic [7:0]        report_length;
  } in_item_t;

  typedef struct packed {
    logic              event_valid;
    logic [CODE_W-1:0] button_code;
    logic [MASK_W-1:0] raw_mask;
    logic              pressed;
    logic              more_pending;
  } out_item_t;

  // One slot of the event ring.
  typedef struct packed {
    logic              pressed;
    logic [CODE_W-1:0] code;
    logic [MASK_W-1:0] mask;
  } entry_t;

  // Work handed from the front to the back.
  typedef struct packed {
    logic              is_pop;
    logic [MASK_W-1:0] old_mask;
    logic [MASK_W-1:0] new_mask;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_UNKNOWN,
    BK_POP
  } back_state_t;

  // Button table: fixed bits first, then the remaining bits in ascending order.
  function automatic logic [MASK_W-1:0] button_bit(input logic [4:0] idx);
    logic [MASK_W-1:0] b;
    case (idx)
      5'd0:    b = 24'h000001;
      5'd1:    b = 24'h000002;
      5'd2:    b = 24'h000004;
      5'd3:    b = 24'h000008;
      5'd4:    b = 24'h000010;
      5'd5:    b = 24'h000020;
      5'd6:    b = 24'h000040;
      5'd7:    b = 24'h000080;
      5'd8:    b = 24'h000100;
      5'd9:    b = 24'h000200;
      5'd10:   b = 24'h000400;
      5'd11:   b = 24'h002000;
      5'd12:   b = 24'h040000;
      5'd13:   b = 24'h080000;
      5'd14:   b = 24'h000800;
      5'd15:   b = 24'h001000;
      5'd16:   b = 24'h004000;
      5'd17:   b = 24'h008000;
      5'd18:   b = 24'h010000;
      5'd19:   b = 24'h020000;
      5'd20:   b = 24'h100000;
      5'd21:   b = 24'h200000;
      5'd22:   b = 24'h400000;
      5'd23:   b = 24'h800000;
      default: b = '0;
    endcase
    return b;
  endfunction

  // Union of the first n table bits.
  function automatic logic [MASK_W-1:0] known_mask(input int n);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (i < n) m = m | button_bit(5'(i));
    end
    return m;
  endfunction

endpackage

>>> hdl/button_report_event_queue.sv
// Button report event queue: a pop result is strobed from a register after its word
// passes the command queue, and after a ring RAM read when the ring is not empty,
// behind any queued work. A changed report holds the back end, one table bit a
// cycle; busy rises when the two-entry command queue is full.
// Synchronous reset clears the previous mask, ring pointers and command queue;
// ring contents are not cleared. The receiver cannot stall results.
module button_report_event_queue
  import evq_pkg::*;
#(
  parameter int QUEUE_SLOTS = 16,
  parameter int NUM_BUTTONS = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_strobe,
  output out_item_t out_data
);

  localparam int PW = $clog2(QUEUE_SLOTS);
  localparam int EW = $bits(entry_t);

  logic          cmdq_full;
  logic          cmdq_not_empty;
  logic          cmd_push;
  logic          cmd_pop;
  cmd_t          front_cmd;
  cmd_t          head_cmd;
  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [PW-1:0] ram_raddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  evq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .cmdq_full (cmdq_full),
    .cmd_push  (cmd_push),
    .cmd       (front_cmd)
  );

  evq_cmd_fifo u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_cmd  (front_cmd),
    .full      (cmdq_full),
    .not_empty (cmdq_not_empty),
    .pop       (cmd_pop),
    .head      (head_cmd)
  );

  evq_back #(
    .QUEUE_SLOTS (QUEUE_SLOTS),
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmdq_not_empty),
    .cmd        (head_cmd),
    .cmd_pop    (cmd_pop),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  evq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_SLOTS)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> hdl/evq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module evq_ram #(
  parameter int WIDTH = 29,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/evq_front.sv
// Front end: accepts words, filters reports and keeps the previous mask.
// Depends on evq_pkg.
module evq_front
  import evq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_item_t in_data,
  output logic     busy,
  input  logic     cmdq_full,
  output logic     cmd_push,
  output cmd_t     cmd
);

  logic [MASK_W-1:0] prev_mask_r, prev_mask_nxt;
  logic              accept;

  assign busy   = cmdq_full;
  assign accept = start && !cmdq_full;

  always_comb begin
    prev_mask_nxt = prev_mask_r;
    cmd_push      = 1'b0;
    cmd.is_pop    = 1'b0;
    cmd.old_mask  = prev_mask_r;
    cmd.new_mask  = in_data.report_mask;
    if (accept) begin
      case (in_data.kind)
        KIND_REPORT: begin
          // drop short and unchanged reports
          if (in_data.report_length >= 8'(MIN_REPORT_BYTES) &&
              in_data.report_mask != prev_mask_r) begin
            cmd_push      = 1'b1;
            prev_mask_nxt = in_data.report_mask;
          end
        end
        KIND_POP: begin
          cmd_push   = 1'b1;
          cmd.is_pop = 1'b1;
        end
        KIND_LINK_RESET: prev_mask_nxt = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_mask_r <= '0;
    end else begin
      prev_mask_r <= prev_mask_nxt;
    end
  end

endmodule

>>> hdl/evq_cmd_fifo.sv
// Two-entry command queue between front and back.
// Depends on evq_pkg.
module evq_cmd_fifo
  import evq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic not_empty,
  input  logic pop,
  output cmd_t head
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> hdl/evq_back.sv
// Back end: scans button changes into the event ring and serves pops.
// Depends on evq_pkg; drives the ring RAM ports.
module evq_back
  import evq_pkg::*;
#(
  parameter int QUEUE_SLOTS = 16,
  parameter int NUM_BUTTONS = 14
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cmd_valid,
  input  cmd_t                           cmd,
  output logic                           cmd_pop,
  output logic                           ram_we,
  output logic [$clog2(QUEUE_SLOTS)-1:0] ram_waddr,
  output logic [$bits(entry_t)-1:0]      ram_wdata,
  output logic [$clog2(QUEUE_SLOTS)-1:0] ram_raddr,
  input  logic [$bits(entry_t)-1:0]      ram_rdata,
  output logic                           out_strobe,
  output out_item_t                      out_data
);

  localparam int PW = $clog2(QUEUE_SLOTS);
  localparam int IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam logic [CODE_W-1:0] UNKNOWN_CODE = CODE_W'(NUM_BUTTONS);
  localparam logic [MASK_W-1:0] KNOWN        = known_mask(NUM_BUTTONS);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  back_state_t       state_r, state_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [PW-1:0]     wp_r, wp_nxt;
  logic [PW-1:0]     rp_r, rp_nxt;
  logic [MASK_W-1:0] old_r, old_nxt;
  logic [MASK_W-1:0] new_r, new_nxt;
  logic              strobe_r, strobe_nxt;
  out_item_t         out_r, out_nxt;
  entry_t            wr_entry;
  entry_t            rd_entry;
  logic              push;
  logic [MASK_W-1:0] cur_bit;
  logic [7:0]        idx_ext;

  assign ram_raddr  = rp_r;
  assign ram_waddr  = wp_r;
  assign ram_we     = push;
  assign ram_wdata  = wr_entry;
  assign rd_entry   = entry_t'(ram_rdata);
  assign out_strobe = strobe_r;
  assign out_data   = out_r;
  assign idx_ext    = 8'(idx_r);
  assign cur_bit    = button_bit(5'(idx_r));

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    old_nxt    = old_r;
    new_nxt    = new_r;
    strobe_nxt = 1'b0;
    out_nxt    = out_r;
    cmd_pop    = 1'b0;
    push       = 1'b0;
    wr_entry   = '{pressed: 1'b1, code: UNKNOWN_CODE, mask: new_r};
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.is_pop) begin
            if (wp_r == rp_r) begin
              strobe_nxt = 1'b1;
              out_nxt    = '0;
            end else begin
              // RAM read of the old pointer lands in BK_POP
              rp_nxt    = ptr_inc(rp_r);
              state_nxt = BK_POP;
            end
          end else begin
            old_nxt   = cmd.old_mask;
            new_nxt   = cmd.new_mask;
            idx_nxt   = '0;
            state_nxt = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        if (((old_r ^ new_r) & cur_bit) != '0) begin
          push     = 1'b1;
          wr_entry = '{pressed: |(new_r & cur_bit), code: idx_ext[CODE_W-1:0],
                       mask: cur_bit};
        end
        if (idx_r == IW'(NUM_BUTTONS - 1)) begin
          state_nxt = BK_UNKNOWN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      BK_UNKNOWN: begin
        if (new_r != '0 && old_r == '0 && (new_r & KNOWN) == '0) push = 1'b1;
        state_nxt = BK_IDLE;
      end
      BK_POP: begin
        strobe_nxt = 1'b1;
        out_nxt    = '{event_valid: 1'b1, button_code: rd_entry.code,
                       raw_mask: rd_entry.mask, pressed: rd_entry.pressed,
                       more_pending: wp_r != rp_r};
        state_nxt  = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
    if (push) begin
      // full ring: drop the oldest word
      wp_nxt = ptr_inc(wp_r);
      if (ptr_inc(wp_r) == rp_r) rp_nxt = ptr_inc(rp_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      wp_r     <= '0;
      rp_r     <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    old_r <= old_nxt;
    new_r <= new_nxt;
    out_r <= out_nxt;
  end

endmodule

>>> hdl/evq_checker.sv
// Port-level checks on the button event queue, bound to the top level.
// Depends on evq_pkg and button_report_event_queue_assert.svh.
`include "button_report_event_queue_assert.svh"

module evq_checker
  import evq_pkg::*;
#(
  parameter int NUM_BUTTONS = 14
) (
  input logic      clk,
  input logic      rst_n,
  input logic      busy,
  input logic      out_strobe,
  input out_item_t out_data
);

  localparam logic [CODE_W-1:0] UNKNOWN_CODE = CODE_W'(NUM_BUTTONS);
  localparam logic              CODES_CLEAR  = (NUM_BUTTONS < 15);

  `EVQ_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_strobe && !busy, "strobe or busy after reset")
  `EVQ_ASSERT(a_empty_zero, out_strobe && !out_data.event_valid |-> out_data == '0, "empty pop not zero")
  `EVQ_ASSERT(a_button_onehot, out_strobe && out_data.event_valid && CODES_CLEAR && out_data.button_code != UNKNOWN_CODE |-> $onehot(out_data.raw_mask), "button word mask not one bit")
  `EVQ_ASSERT(a_unknown_press, out_strobe && out_data.event_valid && CODES_CLEAR && out_data.button_code == UNKNOWN_CODE |-> out_data.pressed && out_data.raw_mask != '0, "bad unknown word")

endmodule

bind button_report_event_queue evq_checker #(.NUM_BUTTONS(NUM_BUTTONS)) u_evq_checker (.*);
